// File: rtl/core/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and codes for the sorted key/tag table.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int unsigned KeyW = 32;
  localparam int unsigned TagW = 32;

  typedef enum logic [1:0] {
    MODE_PUT   = 2'd0,
    MODE_SORT  = 2'd1,
    MODE_GET   = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [TagW-1:0] tag;
  } entry_t;

endpackage

// File: rtl/core/skt_ram.sv
// ----------------------------------------------------------------------------
// skt_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module skt_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = 8
) (
  input  logic               clk_i,
  input  logic               wr_en_i,
  input  logic [AddrW-1:0]   wr_addr_i,
  input  skt_pkg::entry_t    wr_data_i,
  input  logic               rd_en_i,
  input  logic [AddrW-1:0]   rd_addr_i,
  output skt_pkg::entry_t    rd_data_o
);
  import skt_pkg::*;

  entry_t mem [Depth];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/core/skt_ctrl.sv
// ----------------------------------------------------------------------------
// skt_ctrl
// Sequencer: append, clear, insertion sort and binary search over the store.
// ----------------------------------------------------------------------------
module skt_ctrl #(
  parameter int unsigned Capacity = 256,
  parameter int unsigned AddrW    = 8,
  parameter int unsigned CntW     = 9
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [1:0]               mode_i,
  input  logic [skt_pkg::KeyW-1:0] key_i,
  input  logic [skt_pkg::TagW-1:0] tag_in_i,
  output logic                     done_o,
  output logic                     found_o,
  output logic [skt_pkg::TagW-1:0] tag_out_o,
  output logic                     full_reject_o,
  output logic                     rd_en_o,
  output logic [AddrW-1:0]         rd_addr_o,
  input  skt_pkg::entry_t          rd_data_i,
  output logic                     wr_en_o,
  output logic [AddrW-1:0]         wr_addr_o,
  output skt_pkg::entry_t          wr_data_o
);
  import skt_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_PLACE = 3'd3;
  localparam logic [2:0] ST_SRCH  = 3'd4;

  localparam logic [CntW-1:0] CapCnt = CntW'(Capacity);

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] i_q, i_d;
  logic [AddrW-1:0] j_q, j_d;
  entry_t          x_q, x_d;
  logic [KeyW-1:0] key_q, key_d;
  logic [CntW-1:0] lo_q, lo_d;
  logic [CntW-1:0] hi_q, hi_d;
  logic [AddrW-1:0] mid_q, mid_d;
  logic            done_q, done_d;
  logic            found_q, found_d;
  logic [TagW-1:0] tag_q, tag_d;
  logic            reject_q, reject_d;

  mode_e           mode;
  logic            accept;
  logic [CntW-1:0] mid_ext;
  logic [CntW-1:0] mid_inc;
  logic [CntW:0]   sum_lt;
  logic [CntW:0]   sum_gt;
  logic [CntW:0]   sum_first;
  logic [CntW-1:0] i_inc;

  assign mode      = mode_e'(mode_i);
  assign accept    = start_i && (state_q == ST_IDLE);
  assign mid_ext   = CntW'(mid_q);
  assign mid_inc   = mid_ext + CntW'(1);
  assign sum_lt    = (CntW+1)'(lo_q) + (CntW+1)'(mid_ext) - (CntW+1)'(1);
  assign sum_gt    = (CntW+1)'(mid_ext) + (CntW+1)'(hi_q);
  assign sum_first = (CntW+1)'(count_q) - (CntW+1)'(1);
  assign i_inc     = i_q + CntW'(1);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    i_d       = i_q;
    j_d       = j_q;
    x_d       = x_q;
    key_d     = key_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    done_d    = 1'b0;
    found_d   = found_q;
    tag_d     = tag_q;
    reject_d  = reject_q;
    rd_en_o   = 1'b0;
    rd_addr_o = '0;
    wr_en_o   = 1'b0;
    wr_addr_o = '0;
    wr_data_o = x_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          found_d  = 1'b0;
          tag_d    = '0;
          reject_d = 1'b0;
          case (mode)
            MODE_PUT: begin
              done_d = 1'b1;
              if (count_q == CapCnt) begin
                reject_d = 1'b1;
              end else begin
                wr_en_o   = 1'b1;
                wr_addr_o = count_q[AddrW-1:0];
                wr_data_o = '{key: key_i, tag: tag_in_i};
                count_d   = count_q + CntW'(1);
              end
            end
            MODE_SORT: begin
              if (count_q < CntW'(2)) begin
                done_d = 1'b1;
              end else begin
                i_d       = CntW'(1);
                rd_en_o   = 1'b1;
                rd_addr_o = AddrW'(1);
                state_d   = ST_LOAD;
              end
            end
            MODE_GET: begin
              key_d = key_i;
              if (count_q == '0) begin
                done_d = 1'b1;
              end else begin
                lo_d      = '0;
                hi_d      = count_q;
                mid_d     = AddrW'(sum_first >> 1);
                rd_en_o   = 1'b1;
                rd_addr_o = AddrW'(sum_first >> 1);
                state_d   = ST_SRCH;
              end
            end
            MODE_CLEAR: begin
              count_d = '0;
              done_d  = 1'b1;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      ST_LOAD: begin
        x_d       = rd_data_i;
        j_d       = i_q[AddrW-1:0];
        rd_en_o   = 1'b1;
        rd_addr_o = i_q[AddrW-1:0] - AddrW'(1);
        state_d   = ST_SCAN;
      end

      ST_SCAN: begin
        if (x_q.key < rd_data_i.key) begin
          wr_en_o   = 1'b1;
          wr_addr_o = j_q;
          wr_data_o = rd_data_i;
          j_d       = j_q - AddrW'(1);
          if (j_q == AddrW'(1)) begin
            state_d = ST_PLACE;
          end else begin
            rd_en_o   = 1'b1;
            rd_addr_o = j_q - AddrW'(2);
          end
        end else begin
          state_d = ST_PLACE;
        end
      end

      ST_PLACE: begin
        wr_en_o   = 1'b1;
        wr_addr_o = j_q;
        wr_data_o = x_q;
        i_d       = i_inc;
        if (i_inc == count_q) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          rd_en_o   = 1'b1;
          rd_addr_o = i_inc[AddrW-1:0];
          state_d   = ST_LOAD;
        end
      end

      ST_SRCH: begin
        if (key_q == rd_data_i.key) begin
          found_d = 1'b1;
          tag_d   = rd_data_i.tag;
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else if (key_q < rd_data_i.key) begin
          if (lo_q >= mid_ext) begin
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end else begin
            hi_d      = mid_ext;
            mid_d     = AddrW'(sum_lt >> 1);
            rd_en_o   = 1'b1;
            rd_addr_o = AddrW'(sum_lt >> 1);
          end
        end else begin
          if (mid_inc >= hi_q) begin
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end else begin
            lo_d      = mid_inc;
            mid_d     = AddrW'(sum_gt >> 1);
            rd_en_o   = 1'b1;
            rd_addr_o = AddrW'(sum_gt >> 1);
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      done_q   <= 1'b0;
      found_q  <= 1'b0;
      tag_q    <= '0;
      reject_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      done_q   <= done_d;
      found_q  <= found_d;
      tag_q    <= tag_d;
      reject_q <= reject_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q   <= i_d;
    j_q   <= j_d;
    x_q   <= x_d;
    key_q <= key_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    mid_q <= mid_d;
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign found_o       = found_q;
  assign tag_out_o     = tag_q;
  assign full_reject_o = reject_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapCnt)
    else $error("entry count above capacity");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == ST_IDLE))
    else $error("result strobe while sequencer still busy");

  a_full_put: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (mode == MODE_PUT) && (count_q == CapCnt))
      |=> (done_q && reject_q && (count_q == CapCnt)))
    else $error("put to full table not rejected");

  a_srch_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SRCH) |-> ((lo_q <= mid_ext) && (mid_ext < hi_q) && (hi_q <= count_q)))
    else $error("search probe outside window");

  a_excl_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !(found_q && reject_q))
    else $error("found and reject both set");
`endif

endmodule

// File: rtl/core/sorted_key_tag_table.sv
// ----------------------------------------------------------------------------
// sorted_key_tag_table
// Key/tag table with append, in-place insertion sort and binary search.
//
//   channel   direction  handshake            payload
//   command   in         start & !busy        mode_i, key_i, tag_in_i
//   result    out        done_o (one cycle)   found_o, tag_out_o, full_reject_o
//
// Put and clear: result in the cycle after the command.
// Get: one store read per probe, 1 to floor(log2(count))+1 probes; none if empty.
// Sort: per element one load, one compare per scanned neighbor (larger keys
//   shift up a slot), then one place step.
// Reset clears the entry count and control state; store contents are kept.
// busy is high while a sort or get walks the store; results cannot be stalled.
// ----------------------------------------------------------------------------
module sorted_key_tag_table #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               mode_i,
  input  logic [skt_pkg::KeyW-1:0] key_i,
  input  logic [skt_pkg::TagW-1:0] tag_in_i,
  output logic                     done_o,
  output logic                     found_o,
  output logic [skt_pkg::TagW-1:0] tag_out_o,
  output logic                     full_reject_o
);
  import skt_pkg::*;

  localparam int unsigned AddrW = $clog2(CAPACITY);
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);

  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  entry_t           rd_data;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  entry_t           wr_data;

  skt_ctrl #(
    .Capacity (CAPACITY),
    .AddrW    (AddrW),
    .CntW     (CntW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_o        (busy),
    .mode_i        (mode_i),
    .key_i         (key_i),
    .tag_in_i      (tag_in_i),
    .done_o        (done_o),
    .found_o       (found_o),
    .tag_out_o     (tag_out_o),
    .full_reject_o (full_reject_o),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr),
    .rd_data_i     (rd_data),
    .wr_en_o       (wr_en),
    .wr_addr_o     (wr_addr),
    .wr_data_o     (wr_data)
  );

  skt_ram #(
    .Depth (CAPACITY),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

endmodule

// File: sim/tb_sorted_key_tag_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_key_tag_table
// Self-checking bench for the sorted key/tag table. A directed table covers
// the empty table, extreme keys and tags, duplicates, clear, and get on
// unsorted contents. A fill to capacity checks dropped puts. Random sessions
// follow: mostly clear, puts, sort, gets; also unsorted gets, mixed ops, fills.
// Results are checked in order against an in-bench model or a row's reply.
// ----------------------------------------------------------------------------
module tb_sorted_key_tag_table;
  import skt_pkg::*;

  localparam int unsigned TABLE_DEPTH  = 256;
  localparam int          RANDOM_ITEMS = 1450;
  localparam int          STALL_LIMIT  = 250000;
  localparam int          DRAIN_CYCLES = 16;

  typedef struct packed {
    logic            found;
    logic [TagW-1:0] tag;
    logic            reject;
  } reply_t;

  typedef struct packed {
    mode_e           op;
    logic [KeyW-1:0] key;
    logic [TagW-1:0] tag;
    logic            typed;
    reply_t          want;
  } dir_row_t;

  localparam reply_t NO_REPLY    = '0;
  localparam reply_t FULL_REJECT = '{1'b0, 32'h0, 1'b1};

  localparam dir_row_t DIRECTED [0:21] = '{
    '{MODE_GET,   32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0, 1'b0}},
    '{MODE_SORT,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0, 1'b0}},
    '{MODE_CLEAR, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 1'b0}},
    '{MODE_PUT,   32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 1'b0}},
    '{MODE_PUT,   32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0, 1'b0}},
    '{MODE_PUT,   32'h8000_0000, 32'hA5A5_A5A5, 1'b1, '{1'b0, 32'h0, 1'b0}},
    '{MODE_PUT,   32'h0000_0000, 32'h0000_0001, 1'b1, '{1'b0, 32'h0, 1'b0}},
    // unsorted contents: search runs on the raw order
    '{MODE_GET,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '{1'b0, 32'h0, 1'b0}},
    '{MODE_GET,   32'h8000_0000, 32'h0000_0000, 1'b0, '{1'b0, 32'h0, 1'b0}},
    '{MODE_SORT,  32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 1'b0}},
    '{MODE_GET,   32'h0000_0000, 32'h0000_0000, 1'b0, '{1'b0, 32'h0, 1'b0}},
    '{MODE_GET,   32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '{1'b0, 32'h0, 1'b0}},
    '{MODE_GET,   32'h8000_0000, 32'hFFFF_FFFF, 1'b0, '{1'b0, 32'h0, 1'b0}},
    '{MODE_GET,   32'h7FFF_FFFF, 32'h0000_0000, 1'b0, '{1'b0, 32'h0, 1'b0}},
    '{MODE_PUT,   32'h0000_0000, 32'h5A5A_5A5A, 1'b1, '{1'b0, 32'h0, 1'b0}},
    '{MODE_SORT,  32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 1'b0}},
    '{MODE_GET,   32'h0000_0000, 32'h0000_0000, 1'b0, '{1'b0, 32'h0, 1'b0}},
    '{MODE_CLEAR, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 1'b0}},
    '{MODE_GET,   32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 1'b0}},
    '{MODE_PUT,   32'h5555_5555, 32'hAAAA_AAAA, 1'b1, '{1'b0, 32'h0, 1'b0}},
    '{MODE_GET,   32'h5555_5555, 32'h0000_0000, 1'b1, '{1'b1, 32'hAAAA_AAAA, 1'b0}},
    '{MODE_CLEAR, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1, '{1'b0, 32'h0, 1'b0}}
  };

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            start;
  logic            busy;
  logic [1:0]      mode_i;
  logic [KeyW-1:0] key_i;
  logic [TagW-1:0] tag_in_i;
  logic            done_o;
  logic            found_o;
  logic [TagW-1:0] tag_out_o;
  logic            full_reject_o;

  logic [KeyW-1:0] exp_keys [TABLE_DEPTH];
  logic [TagW-1:0] exp_tags [TABLE_DEPTH];
  int              exp_count;
  reply_t          pending_replies [$];

  int err_cnt = 0;
  int items_sent;
  int stall_cycles = 0;
  int n_puts, n_drops, n_sorts, n_gets, n_hits, n_clears;

  sorted_key_tag_table #(
    .CAPACITY(TABLE_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .mode_i       (mode_i),
    .key_i        (key_i),
    .tag_in_i     (tag_in_i),
    .done_o       (done_o),
    .found_o      (found_o),
    .tag_out_o    (tag_out_o),
    .full_reject_o(full_reject_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic reply_t predict_table_op(mode_e op, logic [KeyW-1:0] k,
                                              logic [TagW-1:0] t);
    reply_t          r;
    int              lo, hi, mid, j;
    logic [KeyW-1:0] sk;
    logic [TagW-1:0] st;
    r = NO_REPLY;
    case (op)
      MODE_PUT: begin
        if (exp_count >= TABLE_DEPTH) begin
          r.reject = 1'b1;
        end else begin
          exp_keys[exp_count] = k;
          exp_tags[exp_count] = t;
          exp_count++;
        end
      end
      MODE_SORT: begin
        for (int i = 1; i < exp_count; i++) begin
          j = i;
          while (j >= 1 && exp_keys[j] < exp_keys[j-1]) begin
            sk = exp_keys[j];
            st = exp_tags[j];
            exp_keys[j]   = exp_keys[j-1];
            exp_tags[j]   = exp_tags[j-1];
            exp_keys[j-1] = sk;
            exp_tags[j-1] = st;
            j--;
          end
        end
      end
      MODE_GET: begin
        lo = 0;
        hi = exp_count - 1;
        while (lo <= hi) begin
          mid = lo + (hi - lo) / 2;
          if (k < exp_keys[mid]) begin
            hi = mid - 1;
          end else if (k > exp_keys[mid]) begin
            lo = mid + 1;
          end else begin
            r.found = 1'b1;
            r.tag   = exp_tags[mid];
            lo      = hi + 1;
          end
        end
      end
      default: begin
        exp_count = 0;
      end
    endcase
    return r;
  endfunction

  // 0: narrow range (many duplicates), 1: full range, else near the extremes
  function automatic logic [KeyW-1:0] pick_key(int style);
    case (style)
      0:       return KeyW'($urandom_range(0, 15));
      1:       return $urandom;
      default: return ($urandom_range(0, 1) ? 32'hFFFF_FFF0 : 32'h0) |
                      KeyW'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic logic [KeyW-1:0] probe_key(int style);
    logic [KeyW-1:0] k;
    if (exp_count > 0 && $urandom_range(0, 3) != 0) begin
      k = exp_keys[$urandom_range(0, exp_count - 1)];
      if ($urandom_range(0, 6) == 0) k = k + 1;
      return k;
    end
    return pick_key(style);
  endfunction

  // Called right after a rising edge; returns at the edge that took the item.
  task automatic issue(input mode_e op, input logic [KeyW-1:0] k,
                       input logic [TagW-1:0] t, input bit typed = 1'b0,
                       input reply_t want = NO_REPLY);
    reply_t r;
    int     gap_pct;
    gap_pct = (items_sent < 600) ? 35 : (items_sent < 1200) ? 66 : 0;
    while ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start    <= 1'b1;
    mode_i   <= op;
    key_i    <= k;
    tag_in_i <= t;
    do @(posedge clk_i); while (busy);
    r = predict_table_op(op, k, t);
    pending_replies.push_back(typed ? want : r);
    items_sent++;
    case (op)
      MODE_PUT: begin
        n_puts++;
        if (r.reject) n_drops++;
      end
      MODE_SORT: n_sorts++;
      MODE_GET: begin
        n_gets++;
        if (r.found) n_hits++;
      end
      default: n_clears++;
    endcase
  endtask

  // Clear, fill to capacity, then overflow puts, sort, six lookups and a clear.
  task automatic fill_table(input bit descending);
    int style;
    style = $urandom_range(0, 2);
    issue(MODE_CLEAR, $urandom, $urandom);
    while (exp_count < TABLE_DEPTH) begin
      issue(MODE_PUT, descending ? 32'hFFFF_FFFF - KeyW'(exp_count / 2) : pick_key(style),
            $urandom);
    end
    repeat ($urandom_range(1, 3)) issue(MODE_PUT, $urandom, $urandom, 1'b1, FULL_REJECT);
    issue(MODE_SORT, $urandom, $urandom);
    repeat (6) issue(MODE_GET, probe_key(style), $urandom);
    issue(MODE_CLEAR, $urandom, $urandom);
  endtask

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && done_o) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: result with none pending: expected none, got found %b tag %h rej %b",
                 $time, found_o, tag_out_o, full_reject_o);
        err_cnt++;
      end else begin
        want = pending_replies.pop_front();
        check_field("found", 32'(want.found), 32'(found_o));
        check_field("tag_out", want.tag, tag_out_o);
        check_field("full_reject", 32'(want.reject), 32'(full_reject_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    int dir_items;
    int sel, style, n;
    start    = 1'b0;
    mode_i   = MODE_PUT;
    key_i    = '0;
    tag_in_i = '0;
    rst_ni   = 1'b0;
    items_sent   = 0;
    exp_count    = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i]) begin
      issue(DIRECTED[i].op, DIRECTED[i].key, DIRECTED[i].tag, DIRECTED[i].typed,
            DIRECTED[i].want);
    end
    fill_table(1'b1);

    dir_items = items_sent;
    while (items_sent < dir_items + RANDOM_ITEMS) begin
      sel   = $urandom_range(0, 99);
      style = $urandom_range(0, 2);
      if (sel < 60) begin
        if ($urandom_range(0, 4) != 0) issue(MODE_CLEAR, $urandom, $urandom);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
        repeat (n) issue(MODE_PUT, pick_key(style), $urandom);
        issue(MODE_SORT, $urandom, $urandom);
        repeat ($urandom_range(1, 10)) issue(MODE_GET, probe_key(style), $urandom);
      end else if (sel < 80) begin
        // lookups on unsorted contents
        if ($urandom_range(0, 1) != 0) issue(MODE_CLEAR, $urandom, $urandom);
        repeat ($urandom_range(2, 12)) begin
          if ($urandom_range(0, 2) == 0) issue(MODE_GET, probe_key(style), $urandom);
          else issue(MODE_PUT, pick_key(style), $urandom);
        end
      end else if (sel < 99) begin
        repeat ($urandom_range(1, 8)) begin
          issue(mode_e'($urandom_range(0, 3)), $urandom, $urandom);
        end
      end else begin
        fill_table(1'b0);
      end
    end
    start <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d items: %0d puts (%0d dropped on full), %0d sorts, %0d gets",
             items_sent, n_puts, n_drops, n_sorts, n_gets);
    $display("  %0d gets hit, %0d clears; sender gaps at 35%%, 66%%, then none",
             n_hits, n_clears);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/skt_pkg.sv
rtl/core/skt_ram.sv
rtl/core/skt_ctrl.sv
rtl/core/sorted_key_tag_table.sv
sim/tb_sorted_key_tag_table.sv
